FILE: rtl/mxp_pkg.sv
`timescale 1ns / 1ps

package mxp_pkg;

  // field widths
  localparam int unsigned MOD_W    = 31;
  localparam int unsigned BASE_W   = 63;
  localparam int unsigned EXP_W    = 63;

  // exponent bits actually scanned (8..63)
  localparam int unsigned EXP_BITS = 63;

  localparam int unsigned ECNT_W   = $clog2(EXP_BITS);
  localparam int unsigned BCNT_W   = $clog2(BASE_W);
  localparam int unsigned MCNT_W   = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  // config port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_MODULUS = 1'b0;  // word index, paddr[2]

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_DBL,
    ST_BASE_ADD,
    ST_NORM,
    ST_NEXT,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

FILE: rtl/mxp_mod_add.sv
`timescale 1ns / 1ps

// (a + b) mod m, valid when a + b < 2m
module mxp_mod_add (
  input  logic [mxp_pkg::MOD_W-1:0] a_i,
  input  logic [mxp_pkg::MOD_W-1:0] b_i,
  input  logic [mxp_pkg::MOD_W-1:0] m_i,
  output logic [mxp_pkg::MOD_W-1:0] sum_o
);

  logic [mxp_pkg::MOD_W:0] sum;
  logic [mxp_pkg::MOD_W:0] diff;

  always_comb begin
    sum  = {1'b0, a_i} + {1'b0, b_i};
    diff = sum - {1'b0, m_i};
    if (sum >= {1'b0, m_i}) begin
      sum_o = diff[mxp_pkg::MOD_W-1:0];
    end else begin
      sum_o = sum[mxp_pkg::MOD_W-1:0];
    end
  end

endmodule

FILE: rtl/mxp_engine.sv
`timescale 1ns / 1ps

// Sequencer around one shared modular adder.
// Base reduction: bm = 2bm (+1) per base bit.
// Multiply: interleaved double / add per multiplier bit.
module mxp_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mxp_pkg::BASE_W-1:0]   base_i,
  input  logic [mxp_pkg::EXP_W-1:0]    exp_i,
  input  logic [mxp_pkg::MOD_W-1:0]    mod_i,
  input  logic                         res_ready_i,
  output mxp_pkg::eng_stat_t           stat_o,
  output logic [mxp_pkg::MOD_W-1:0]    result_o
);

  mxp_pkg::state_e state_q, state_d;

  logic [mxp_pkg::MOD_W-1:0]    mod_q, mod_d;
  logic [mxp_pkg::BASE_W-1:0]   base_q, base_d;
  logic [mxp_pkg::EXP_BITS-1:0] e_q, e_d;
  logic [mxp_pkg::MOD_W-1:0]    bm_q, bm_d;
  logic [mxp_pkg::MOD_W-1:0]    r_q, r_d;
  logic [mxp_pkg::MOD_W-1:0]    acc_q, acc_d;
  logic [mxp_pkg::MOD_W-1:0]    mx_q, mx_d;
  logic [mxp_pkg::MOD_W-1:0]    my_q, my_d;
  logic [mxp_pkg::BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic [mxp_pkg::ECNT_W-1:0]   ecnt_q, ecnt_d;
  logic [mxp_pkg::MCNT_W-1:0]   mcnt_q, mcnt_d;
  logic                         sq_q, sq_d;

  logic [mxp_pkg::MOD_W-1:0]    ua, ub, sum;
  logic                         base_adv;
  logic                         mul_adv;

  mxp_mod_add u_add (
    .a_i   (ua),
    .b_i   (ub),
    .m_i   (mod_q),
    .sum_o (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mxp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    base_q <= base_d;
    e_q    <= e_d;
    bm_q   <= bm_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    bcnt_q <= bcnt_d;
    ecnt_q <= ecnt_d;
    mcnt_q <= mcnt_d;
    sq_q   <= sq_d;
  end

  always_comb begin
    state_d  = state_q;
    mod_d    = mod_q;
    base_d   = base_q;
    e_d      = e_q;
    bm_d     = bm_q;
    r_d      = r_q;
    acc_d    = acc_q;
    mx_d     = mx_q;
    my_d     = my_q;
    bcnt_d   = bcnt_q;
    ecnt_d   = ecnt_q;
    mcnt_d   = mcnt_q;
    sq_d     = sq_q;
    ua       = acc_q;
    ub       = acc_q;
    base_adv = 1'b0;
    mul_adv  = 1'b0;

    case (state_q)
      mxp_pkg::ST_IDLE: begin
        if (start_i) begin
          mod_d  = (mod_i == '0) ? mxp_pkg::MOD_W'(1) : mod_i;
          base_d = base_i;
          e_d    = exp_i[mxp_pkg::EXP_BITS-1:0];
          bm_d   = '0;
          r_d    = '0;
          bcnt_d = mxp_pkg::BCNT_W'(mxp_pkg::BASE_W - 1);
          ecnt_d = mxp_pkg::ECNT_W'(mxp_pkg::EXP_BITS - 1);
          if (exp_i[mxp_pkg::EXP_BITS-1:0] == '0) begin
            state_d = mxp_pkg::ST_DONE;
          end else begin
            state_d = mxp_pkg::ST_BASE_DBL;
          end
        end
      end
      mxp_pkg::ST_BASE_DBL: begin
        ua   = bm_q;
        ub   = bm_q;
        bm_d = sum;
        if (base_q[mxp_pkg::BASE_W-1]) begin
          state_d = mxp_pkg::ST_BASE_ADD;
        end else begin
          base_adv = 1'b1;
        end
      end
      mxp_pkg::ST_BASE_ADD: begin
        ua       = bm_q;
        ub       = mxp_pkg::MOD_W'(1);
        bm_d     = sum;
        base_adv = 1'b1;
      end
      mxp_pkg::ST_NORM: begin
        // shift out leading zeros, then the leading one
        e_d = e_q << 1;
        if (e_q[mxp_pkg::EXP_BITS-1]) begin
          r_d     = bm_q;
          state_d = mxp_pkg::ST_NEXT;
        end else begin
          ecnt_d = ecnt_q - 1'b1;
        end
      end
      mxp_pkg::ST_NEXT: begin
        if (ecnt_q == '0) begin
          state_d = mxp_pkg::ST_DONE;
        end else begin
          mx_d    = r_q;
          my_d    = r_q;
          acc_d   = '0;
          mcnt_d  = mxp_pkg::MCNT_W'(mxp_pkg::MOD_W - 1);
          sq_d    = 1'b1;
          state_d = mxp_pkg::ST_MUL_DBL;
        end
      end
      mxp_pkg::ST_MUL_DBL: begin
        acc_d = sum;
        if (my_q[mxp_pkg::MOD_W-1]) begin
          state_d = mxp_pkg::ST_MUL_ADD;
        end else begin
          mul_adv = 1'b1;
        end
      end
      mxp_pkg::ST_MUL_ADD: begin
        ub      = mx_q;
        acc_d   = sum;
        mul_adv = 1'b1;
      end
      mxp_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = mxp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mxp_pkg::ST_IDLE;
      end
    endcase

    if (base_adv) begin
      base_d = base_q << 1;
      if (bcnt_q == '0) begin
        state_d = mxp_pkg::ST_NORM;
      end else begin
        bcnt_d  = bcnt_q - 1'b1;
        state_d = mxp_pkg::ST_BASE_DBL;
      end
    end

    if (mul_adv) begin
      my_d = my_q << 1;
      if (mcnt_q != '0) begin
        mcnt_d  = mcnt_q - 1'b1;
        state_d = mxp_pkg::ST_MUL_DBL;
      end else begin
        r_d = sum;
        if (sq_q && e_q[mxp_pkg::EXP_BITS-1]) begin
          // square done, bit is one: multiply by reduced base
          mx_d    = sum;
          my_d    = bm_q;
          acc_d   = '0;
          mcnt_d  = mxp_pkg::MCNT_W'(mxp_pkg::MOD_W - 1);
          sq_d    = 1'b0;
          state_d = mxp_pkg::ST_MUL_DBL;
        end else begin
          e_d     = e_q << 1;
          ecnt_d  = ecnt_q - 1'b1;
          state_d = mxp_pkg::ST_NEXT;
        end
      end
    end
  end

  assign stat_o.idle = (state_q == mxp_pkg::ST_IDLE);
  assign stat_o.done = (state_q == mxp_pkg::ST_DONE);
  assign result_o    = r_q;

  a_bm_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mxp_pkg::ST_IDLE) |-> (bm_q < mod_q))
    else $error("reduced base not below modulus");

  a_mul_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxp_pkg::ST_MUL_DBL || state_q == mxp_pkg::ST_MUL_ADD)
      |-> (acc_q < mod_q && mx_q < mod_q))
    else $error("multiply operand out of range");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxp_pkg::ST_NORM) |-> (e_q != '0))
    else $error("normalize entered with zero exponent");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxp_pkg::ST_DONE) |-> (r_q < mod_q))
    else $error("result not below modulus");

endmodule

FILE: rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    base_value_i[62:0], exponent_value_i[62:0]
// output    out        out_valid_o / out_ready_i  power_residue_o[30:0]
// config    in         psel/penable/pwrite        paddr[2:0], pwdata[31:0] -> prdata
//
// Operation: one item at a time through a single shared modular adder. Base reduction
//   doubles per base bit and adds one per set bit, exponent normalization shifts out the
//   leading zeros and the leading one, then each exponent bit below the leading one costs
//   a square and, when the bit is set, a multiply; a zero exponent goes straight to done.
// Reset: modulus returns to 1000000007, engine idle, output register empty.
// Stalls: a finished result parks in the output register; the next item is taken once
//   the engine is back in idle, even while that result waits.
module modular_exponentiation_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mxp_pkg::BASE_W-1:0]    base_value_i,
  input  logic [mxp_pkg::EXP_W-1:0]     exponent_value_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mxp_pkg::MOD_W-1:0]     power_residue_o,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mxp_pkg::PADDR_W-1:0]   paddr,
  input  logic [mxp_pkg::PDATA_W-1:0]   pwdata,
  output logic [mxp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [mxp_pkg::MOD_W-1:0] modulus_q, modulus_d;
  logic                      out_valid_q, out_valid_d;
  logic [mxp_pkg::MOD_W-1:0] residue_q, residue_d;

  mxp_pkg::eng_stat_t        eng_stat;
  logic [mxp_pkg::MOD_W-1:0] eng_result;
  logic                      start;
  logic                      res_ready;
  logic                      res_load;
  logic                      cfg_wr;

  // ---------------------------------------------------------------------------
  // config register: only the modulus, at word 0
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    modulus_d = modulus_q;
    if (cfg_wr && (paddr[2] == mxp_pkg::REG_MODULUS)) begin
      modulus_d = pwdata[mxp_pkg::MOD_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == mxp_pkg::REG_MODULUS) begin
      prdata = {{(mxp_pkg::PDATA_W - mxp_pkg::MOD_W){1'b0}}, modulus_q};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mxp_pkg::MOD_RESET;
    end else begin
      modulus_q <= modulus_d;
    end
  end

  // ---------------------------------------------------------------------------
  // engine: takes an item only when idle
  // ---------------------------------------------------------------------------
  assign in_ready_o = eng_stat.idle;
  assign start      = in_valid_i && eng_stat.idle;

  mxp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .base_i      (base_value_i),
    .exp_i       (exponent_value_i),
    .mod_i       (modulus_q),
    .res_ready_i (res_ready),
    .stat_o      (eng_stat),
    .result_o    (eng_result)
  );

  // ---------------------------------------------------------------------------
  // output register: frees the engine while the result waits downstream
  // ---------------------------------------------------------------------------
  assign res_ready = !out_valid_q || out_ready_i;
  assign res_load  = eng_stat.done && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    residue_d   = residue_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      residue_d   = eng_result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    residue_q <= residue_d;
  end

  assign out_valid_o     = out_valid_q;
  assign power_residue_o = residue_q;

endmodule
